// ===== hdl/mpcq_pkg.sv =====
// Shared types and constants for the min-priority case queue.
// Holds the table geometry, request and status codes, the stored entry
// layout and the controller-to-datapath command and status structs.
package mpcq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  // The count keeps at least 7 bits so the occupancy port can take its low bits.
  localparam int CNT_W    = ($clog2(CAPACITY + 1) > 7) ? $clog2(CAPACITY + 1) : 7;
  localparam int OCC_W    = 7;

  localparam logic [3:0] PRIO_MIN = 4'd1;
  localparam logic [3:0] PRIO_MAX = 4'd10;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_PEEK   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_INS  = 2'd1,
    RES_BEST = 2'd2
  } res_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_INSERT,
    ST_SCAN,
    ST_SCAN_END,
    ST_SHIFT_SET,
    ST_SHIFT,
    ST_SHIFT_END,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [15:0] serial;
    logic [3:0]  prio;
    logic [15:0] payload;
  } entry_t;

  typedef struct packed {
    logic     load;       // latch an accepted item
    logic     ins;        // append the latched entry
    logic     scan_rd;    // read the next entry for the minimum search
    logic     shift_set;  // point the shift just past the found entry
    logic     shift_rd;   // read the next entry to move down
    logic     dec;        // drop one entry from the count
    logic     res_load;   // capture a result
    res_sel_t res_sel;
    status_t  res_status;
    logic     out_load;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic prio_bad;
    logic scan_last;
    logic shift_end;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/mpcq_ctrl.sv =====
// Controller state machine for the min-priority case queue.
// Sequences insert, minimum scan, shift-down and output hand-off.
// Depends on mpcq_pkg.
module mpcq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mpcq_pkg::sts_t sts,
  output mpcq_pkg::cmd_t cmd
);

  mpcq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpcq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.res_sel    = mpcq_pkg::RES_ZERO;
    cmd.res_status = mpcq_pkg::STAT_OK;
    case (state)
      mpcq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mpcq_pkg::ST_DECIDE;
        end
      end
      mpcq_pkg::ST_DECIDE: begin
        case (sts.req)
          mpcq_pkg::REQ_INSERT: begin
            if (sts.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = mpcq_pkg::STAT_FULL;
              state_next     = mpcq_pkg::ST_OUT;
            end else if (sts.prio_bad) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = mpcq_pkg::STAT_RANGE;
              state_next     = mpcq_pkg::ST_OUT;
            end else begin
              state_next = mpcq_pkg::ST_INSERT;
            end
          end
          mpcq_pkg::REQ_PEEK, mpcq_pkg::REQ_REMOVE: begin
            if (sts.empty) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = mpcq_pkg::STAT_EMPTY;
              state_next     = mpcq_pkg::ST_OUT;
            end else begin
              state_next = mpcq_pkg::ST_SCAN;
            end
          end
          default: begin
            cmd.res_load = 1'b1;
            state_next   = mpcq_pkg::ST_OUT;
          end
        endcase
      end
      mpcq_pkg::ST_INSERT: begin
        cmd.ins      = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = mpcq_pkg::RES_INS;
        state_next   = mpcq_pkg::ST_OUT;
      end
      mpcq_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = mpcq_pkg::ST_SCAN_END;
        end
      end
      mpcq_pkg::ST_SCAN_END: begin
        // The last entry read is compared at this edge.
        if (sts.req == mpcq_pkg::REQ_REMOVE) begin
          state_next = mpcq_pkg::ST_SHIFT_SET;
        end else begin
          state_next = mpcq_pkg::ST_FINISH;
        end
      end
      mpcq_pkg::ST_SHIFT_SET: begin
        cmd.shift_set = 1'b1;
        state_next    = mpcq_pkg::ST_SHIFT;
      end
      mpcq_pkg::ST_SHIFT: begin
        if (sts.shift_end) begin
          state_next = mpcq_pkg::ST_SHIFT_END;
        end else begin
          cmd.shift_rd = 1'b1;
        end
      end
      mpcq_pkg::ST_SHIFT_END: begin
        cmd.dec    = 1'b1;
        state_next = mpcq_pkg::ST_FINISH;
      end
      mpcq_pkg::ST_FINISH: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = mpcq_pkg::RES_BEST;
        state_next   = mpcq_pkg::ST_OUT;
      end
      mpcq_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = mpcq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mpcq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/mpcq_dp.sv =====
// Datapath for the min-priority case queue: entry memory, count and
// serial registers, minimum search, shift-down and the output register.
// Depends on mpcq_pkg; driven by mpcq_ctrl.
module mpcq_dp (
  input  logic           clk,
  input  logic           rst,
  input  mpcq_pkg::cmd_t cmd,
  output mpcq_pkg::sts_t sts,
  input  logic [1:0]     req_type,
  input  logic [3:0]     priority_req,
  input  logic [15:0]    payload,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     status,
  output logic [15:0]    case_id,
  output logic [3:0]     case_priority,
  output logic [15:0]    case_payload,
  output logic [6:0]     occupancy
);

  mpcq_pkg::entry_t mem [mpcq_pkg::CAPACITY];

  logic [mpcq_pkg::CNT_W-1:0] count;
  logic [15:0]                serial;
  mpcq_pkg::req_t             req;
  logic [3:0]                 req_prio;
  logic [15:0]                req_payload;

  logic [mpcq_pkg::CNT_W-1:0] idx;
  logic                       pend;
  logic                       pend_shift;
  logic [mpcq_pkg::CNT_W-1:0] pend_idx;
  mpcq_pkg::entry_t           rd_data;

  mpcq_pkg::entry_t           best;
  logic [mpcq_pkg::CNT_W-1:0] best_idx;

  mpcq_pkg::status_t res_status;
  mpcq_pkg::entry_t  res;

  logic                       rd_en;
  logic                       wr_en;
  logic [mpcq_pkg::IDX_W-1:0] wr_addr;
  mpcq_pkg::entry_t           wr_data;
  logic [mpcq_pkg::CNT_W-1:0] pend_prev;

  assign rd_en     = cmd.scan_rd || cmd.shift_rd;
  assign pend_prev = pend_idx - mpcq_pkg::CNT_W'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[mpcq_pkg::IDX_W-1:0];
    wr_data = '{serial: serial, prio: req_prio, payload: req_payload};
    if (cmd.ins) begin
      wr_en = 1'b1;
    end else if (pend && pend_shift) begin
      wr_en   = 1'b1;
      wr_addr = pend_prev[mpcq_pkg::IDX_W-1:0];
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[idx[mpcq_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      serial     <= 16'd1;
      pend       <= 1'b0;
      pend_shift <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pend       <= rd_en;
      pend_shift <= cmd.shift_rd;
      if (cmd.ins) begin
        count  <= count + mpcq_pkg::CNT_W'(1);
        serial <= serial + 16'd1;
      end else if (cmd.dec) begin
        count <= count - mpcq_pkg::CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req         <= mpcq_pkg::req_t'(req_type);
      req_prio    <= priority_req;
      req_payload <= payload;
    end
    if (cmd.load) begin
      idx <= '0;
    end else if (cmd.shift_set) begin
      idx <= best_idx + mpcq_pkg::CNT_W'(1);
    end else if (rd_en) begin
      idx <= idx + mpcq_pkg::CNT_W'(1);
    end
    if (rd_en) begin
      pend_idx <= idx;
    end
    // Strict less-than keeps the earliest entry among equal priorities.
    if (pend && !pend_shift) begin
      if (pend_idx == '0 || rd_data.prio < best.prio) begin
        best     <= rd_data;
        best_idx <= pend_idx;
      end
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      case (cmd.res_sel)
        mpcq_pkg::RES_INS:  res <= '{serial: serial, prio: req_prio, payload: req_payload};
        mpcq_pkg::RES_BEST: res <= best;
        default:            res <= '0;
      endcase
    end
    if (cmd.out_load) begin
      status        <= res_status;
      case_id       <= res.serial;
      case_priority <= res.prio;
      case_payload  <= res.payload;
      occupancy     <= count[mpcq_pkg::OCC_W-1:0];
    end
  end

  always_comb begin
    sts.req       = req;
    sts.full      = (count == mpcq_pkg::CNT_W'(mpcq_pkg::CAPACITY));
    sts.empty     = (count == '0);
    sts.prio_bad  = (req_prio < mpcq_pkg::PRIO_MIN) || (req_prio > mpcq_pkg::PRIO_MAX);
    sts.scan_last = (idx == count - mpcq_pkg::CNT_W'(1));
    sts.shift_end = (idx == count);
    sts.out_free  = !out_valid || out_ready;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= mpcq_pkg::CNT_W'(mpcq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_ins_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |-> !sts.full)
    else $error("insert into a full table");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + mpcq_pkg::CNT_W'(1))
    else $error("count did not grow on insert");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (pend && !pend_shift) |-> pend_idx < count)
    else $error("search read past the stored entries");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.dec |-> !sts.empty)
    else $error("remove from an empty table");
`endif

endmodule

// ===== hdl/min_priority_case_queue.sv =====
// Min-priority case queue: an unsorted table of up to 64 entries kept in
// insertion order. Request items arrive on the in_valid/in_ready channel
// (req_type, priority_req, payload); one result item per request leaves on
// out_valid/out_ready (status, case_id, case_priority, case_payload,
// occupancy). An insert appends an entry with the next 16-bit serial; a
// peek returns the earliest entry of lowest priority value; a remove also
// takes it out and moves every later entry down one slot.
// The search reads one entry a cycle and the shift moves one entry a cycle:
// the entry memory is read through its read port while its write port
// stores each moved entry one slot down. A stalled receiver holds the result back.
// One item is worked on at a time. The result sits in an output register;
// the next item is accepted while it waits, and that item's result is
// held back until the receiver takes the previous one.
// Reset empties the table, sets the next serial to one and drops any
// pending result; stored entries are left as they are.
// Depends on mpcq_pkg, mpcq_ctrl and mpcq_dp.
module min_priority_case_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [3:0]  priority_req,
  input  logic [15:0] payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] case_id,
  output logic [3:0]  case_priority,
  output logic [15:0] case_payload,
  output logic [6:0]  occupancy
);

  mpcq_pkg::cmd_t cmd;
  mpcq_pkg::sts_t sts;

  mpcq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mpcq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .priority_req  (priority_req),
    .payload       (payload),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .case_id       (case_id),
    .case_priority (case_priority),
    .case_payload  (case_payload),
    .occupancy     (occupancy)
  );

endmodule
